### sv/tun_pkg.sv
// Package for the triangle unit normal block: payload types and fixed widths.
`default_nettype none
package tun_pkg;

  localparam int FIELD_W          = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_W           = NORMAL_FRAC_BITS + 2;
  localparam int COORD_WIDTH_DEF  = 16;

  typedef struct packed {
    logic signed [FIELD_W-1:0] p1_x;
    logic signed [FIELD_W-1:0] p1_y;
    logic signed [FIELD_W-1:0] p1_z;
    logic signed [FIELD_W-1:0] p2_x;
    logic signed [FIELD_W-1:0] p2_y;
    logic signed [FIELD_W-1:0] p2_z;
    logic signed [FIELD_W-1:0] p3_x;
    logic signed [FIELD_W-1:0] p3_y;
    logic signed [FIELD_W-1:0] p3_z;
  } tun_tri_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } tun_nrm_t;

endpackage
`default_nettype wire

### sv/triangle_unit_normal_top.sv
// Pipelined unit face normal of a triangle in fixed point.
//
//   channel   signals                         direction   payload
//   tri       tri_valid, tri_stall, tri_data  in          three vertices, signed Q8.8
//   nrm       nrm_valid, nrm_stall, nrm_data  out         unit normal Q1.14, degenerate
//
// One triangle enters every cycle unless the output is stalled; the pipeline is made of
// six arithmetic stages, one stage per quotient bit of the normalising search,
// and the output register. Reset clears the valid bits only. A stalled output freezes
// the whole pipeline and raises tri_stall in the same cycle.
`default_nettype none
module triangle_unit_normal_top
  import tun_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     tri_valid,
  output logic          tri_stall,
  input  wire tun_tri_t tri_data,
  output logic          nrm_valid,
  input  wire logic     nrm_stall,
  output tun_nrm_t      nrm_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int XW  = CW + FIELD_W;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int CXW = PW + 1;
  localparam int MW  = PW;
  localparam int H   = (MW + 1) / 2;
  localparam int HW  = MW - H;
  localparam int SW  = 2 * MW;
  localparam int LW  = SW + 2;
  localparam int TW  = SW + 2 * F;
  localparam int PPW = LW + 2 * F + 2;
  localparam int QW  = F + 1;
  localparam int NS  = 6 + QW + 1;

  logic          en;
  logic [NS-1:0] vld;

  assign en        = !(nrm_valid && nrm_stall);
  assign tri_stall = !en;
  assign nrm_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], tri_valid};
    end
  end

  logic [FIELD_W-1:0]  rawf [9];
  logic [XW-1:0]       ext  [9];
  logic signed [CW-1:0] crd [9];

  assign rawf[0] = tri_data.p1_x;
  assign rawf[1] = tri_data.p1_y;
  assign rawf[2] = tri_data.p1_z;
  assign rawf[3] = tri_data.p2_x;
  assign rawf[4] = tri_data.p2_y;
  assign rawf[5] = tri_data.p2_z;
  assign rawf[6] = tri_data.p3_x;
  assign rawf[7] = tri_data.p3_y;
  assign rawf[8] = tri_data.p3_z;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ext[i] = XW'(rawf[i]);
      crd[i] = ext[i][CW-1:0];
    end
  end

  // stage 1: edge vectors
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= DW'(crd[0]) - DW'(crd[3]);
      ay <= DW'(crd[1]) - DW'(crd[4]);
      az <= DW'(crd[2]) - DW'(crd[5]);
      bx <= DW'(crd[0]) - DW'(crd[6]);
      by <= DW'(crd[1]) - DW'(crd[7]);
      bz <= DW'(crd[2]) - DW'(crd[8]);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] pr [6];

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= PW'(ay) * PW'(bz);
      pr[1] <= PW'(by) * PW'(az);
      pr[2] <= PW'(bx) * PW'(az);
      pr[3] <= PW'(ax) * PW'(bz);
      pr[4] <= PW'(ax) * PW'(by);
      pr[5] <= PW'(bx) * PW'(ay);
    end
  end

  // stage 3: cross product as sign and magnitude
  logic signed [CXW-1:0] cr [3];
  logic [CXW-1:0]        crm [3];
  logic [MW-1:0]         mag3 [3];
  logic                  neg3 [3];
  logic                  nz3  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cr[j]  = CXW'(pr[2*j]) - CXW'(pr[2*j+1]);
      crm[j] = cr[j][CXW-1] ? -cr[j] : cr[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag3[j] <= crm[j][MW-1:0];
        neg3[j] <= cr[j][CXW-1];
        nz3[j]  <= (cr[j] != '0);
      end
    end
  end

  // stage 4: partial products of the squares
  logic [2*HW-1:0] hh4 [3];
  logic [HW+H-1:0] hm4 [3];
  logic [2*H-1:0]  ll4 [3];
  logic            neg4 [3];
  logic            nz4  [3];
  logic [HW-1:0]   mh [3];
  logic [H-1:0]    ml [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mh[j] = mag3[j][MW-1:H];
      ml[j] = mag3[j][H-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        hh4[j]  <= (2*HW)'(mh[j]) * (2*HW)'(mh[j]);
        hm4[j]  <= (HW+H)'(mh[j]) * (HW+H)'(ml[j]);
        ll4[j]  <= (2*H)'(ml[j]) * (2*H)'(ml[j]);
        neg4[j] <= neg3[j];
        nz4[j]  <= nz3[j];
      end
    end
  end

  // stage 5: squares
  logic [SW-1:0] sq5 [3];
  logic          neg5 [3];
  logic          nz5  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq5[j]  <= (SW'(hh4[j]) << (2*H)) + (SW'(hm4[j]) << (H+1)) + SW'(ll4[j]);
        neg5[j] <= neg4[j];
        nz5[j]  <= nz4[j];
      end
    end
  end

  // stage 6 feeds the search: squared length, targets
  logic [LW-1:0]  it_len [QW+1];
  logic [TW-1:0]  it_tgt [QW+1][3];
  logic [PPW-1:0] it_p   [QW+1][3];
  logic [PPW-1:0] it_l   [QW+1][3];
  logic [QW-1:0]  it_q   [QW+1][3];
  logic           it_neg [QW+1][3];
  logic           it_nz  [QW+1][3];
  logic           it_deg [QW+1];
  logic [LW-1:0]  len6;

  assign len6 = LW'(sq5[0]) + LW'(sq5[1]) + LW'(sq5[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      it_len[0] <= len6;
      it_deg[0] <= (len6 == '0);
      for (int j = 0; j < 3; j++) begin
        it_tgt[0][j] <= TW'(sq5[j]) << (2*F);
        it_p[0][j]   <= '0;
        it_l[0][j]   <= '0;
        it_q[0][j]   <= '0;
        it_neg[0][j] <= neg5[j];
        it_nz[0][j]  <= nz5[j];
      end
    end
  end

  // one quotient bit per stage: keep q*q*len and q*len up to date by adds
  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int I = F - k;
    logic [PPW-1:0] cand [3];
    logic           ok   [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        cand[j] = it_p[k][j] + (it_l[k][j] << (I+1)) + (PPW'(it_len[k]) << (2*I));
        ok[j]   = (cand[j] <= PPW'(it_tgt[k][j]));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_len[k+1] <= it_len[k];
        it_deg[k+1] <= it_deg[k];
        for (int j = 0; j < 3; j++) begin
          it_tgt[k+1][j] <= it_tgt[k][j];
          it_neg[k+1][j] <= it_neg[k][j];
          it_nz[k+1][j]  <= it_nz[k][j];
          if (ok[j]) begin
            it_p[k+1][j] <= cand[j];
            it_l[k+1][j] <= it_l[k][j] + (PPW'(it_len[k]) << I);
            it_q[k+1][j] <= it_q[k][j] | (QW'(1) << I);
          end else begin
            it_p[k+1][j] <= it_p[k][j];
            it_l[k+1][j] <= it_l[k][j];
            it_q[k+1][j] <= it_q[k][j];
          end
        end
      end
    end
  end

  // output register: apply sign, drop zero components
  logic [NORM_W-1:0] nv [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nv[j] = it_nz[QW][j] ? NORM_W'(it_q[QW][j]) : '0;
      if (it_neg[QW][j]) begin
        nv[j] = -nv[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_data.normal_x   <= nv[0];
      nrm_data.normal_y   <= nv[1];
      nrm_data.normal_z   <= nv[2];
      nrm_data.degenerate <= it_deg[QW];
    end
  end

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    nrm_valid && nrm_data.degenerate |->
      nrm_data.normal_x == '0 && nrm_data.normal_y == '0 && nrm_data.normal_z == '0)
    else $error("degenerate result with non-zero normal");

  a_nondeg_nonzero: assert property (@(posedge clk) disable iff (rst)
    nrm_valid && !nrm_data.degenerate |->
      nrm_data.normal_x != '0 || nrm_data.normal_y != '0 || nrm_data.normal_z != '0)
    else $error("non-degenerate result with zero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    nrm_valid |->
      nrm_data.normal_x <= $signed(NORM_W'(1) << F) &&
      nrm_data.normal_x >= -$signed(NORM_W'(1) << F) &&
      nrm_data.normal_y <= $signed(NORM_W'(1) << F) &&
      nrm_data.normal_y >= -$signed(NORM_W'(1) << F) &&
      nrm_data.normal_z <= $signed(NORM_W'(1) << F) &&
      nrm_data.normal_z >= -$signed(NORM_W'(1) << F))
    else $error("normal component beyond unit length");
`endif

endmodule
`default_nettype wire
